// File: rtl/cv_note_step_sequencer_top_assert.svh
// Assertion macros for the note step sequencer.
`ifndef CV_NOTE_STEP_SEQUENCER_TOP_ASSERT_SVH
`define CV_NOTE_STEP_SEQUENCER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define CVSS_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("cvss assertion failed");
`define CVSS_ASSERT_NXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("cvss assertion failed");
`else
`define CVSS_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define CVSS_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

// File: rtl/cvss_pkg.sv
// Shared types and constants for the note step sequencer.
`default_nettype none
package cvss_pkg;

  localparam int MAX_STEPS_DEF = 32;

  localparam logic [2:0] CMD_GATE   = 3'd0;
  localparam logic [2:0] CMD_APPEND = 3'd1;
  localparam logic [2:0] CMD_DELETE = 3'd2;
  localparam logic [2:0] CMD_SEMI   = 3'd3;
  localparam logic [2:0] CMD_OCTAVE = 3'd4;

  localparam logic [1:0] CFG_NOTE_FLOOR   = 2'd0;
  localparam logic [1:0] CFG_NOTE_CEILING = 2'd1;
  localparam logic [1:0] CFG_OCT_LOWEST   = 2'd2;
  localparam logic [1:0] CFG_OCT_HIGHEST  = 2'd3;

  localparam logic [6:0]        FLOOR_RST    = 7'd0;
  localparam logic [6:0]        CEILING_RST  = 7'd120;
  localparam logic signed [3:0] OCT_LOW_RST  = -4'sd2;
  localparam logic [2:0]        OCT_HIGH_RST = 3'd2;

  localparam logic signed [8:0] NOTE_OFFSET = 9'sd60;
  localparam logic [12:0]       DAC_MAX     = 13'd4095;
  localparam logic signed [5:0] SEMI_LIMIT  = 6'sd11;
  localparam logic signed [5:0] OCT_SEMIS   = 6'sd12;

  localparam logic [7:0] AMT_SEMI_UP   = 8'h01;
  localparam logic [7:0] AMT_SEMI_DOWN = 8'hFF;
  localparam logic [7:0] AMT_OCT_UP    = 8'h0C;
  localparam logic [7:0] AMT_OCT_DOWN  = 8'hF4;

  typedef struct packed {
    logic [2:0]        cmd;
    logic              gate_level;
    logic signed [7:0] note_value;
    logic              step_up;
  } in_item_t;

  typedef struct packed {
    logic [11:0] dac_code;
    logic [4:0]  step_index;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic mod_step;
    logic rd_play;
    logic clamp;
    logic emit;
    logic shift_rd;
  } ctl_cmd_t;

  typedef struct packed {
    logic go_mod;
    logic go_shift;
    logic mod_last;
    logic shift_last;
  } dp_stat_t;

endpackage
`default_nettype wire

// File: rtl/cvss_datapath.sv
// Datapath: note memory, sequence state, playhead modulo unit, DAC code path.
`default_nettype none
module cvss_datapath import cvss_pkg::*; #(
  parameter int MAX_STEPS = MAX_STEPS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire in_item_t   in_data,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_idx,
  input  wire logic [6:0] cfg_wdata,
  input  wire ctl_cmd_t   cmd,
  output dp_stat_t        stat,
  output logic            out_valid,
  output out_item_t       out_data
);

  localparam int AW = $clog2(MAX_STEPS);
  localparam int LW = $clog2(MAX_STEPS + 1);
  localparam int KW = $clog2(LW);

  logic [7:0] mem [MAX_STEPS];
  logic [7:0] rd_data_r;

  logic [LW-1:0] seq_len_r;
  logic [AW-1:0] playhead_r;
  logic          gate_seen_r;
  logic signed [4:0] semis_r;
  logic signed [3:0] octave_r;

  logic [6:0]        floor_r;
  logic [6:0]        ceiling_r;
  logic signed [3:0] oct_low_r;
  logic [2:0]        oct_high_r;

  logic [LW-1:0] rem_r;
  logic [KW-1:0] k_r;
  logic [AW-1:0] walk_idx_r;
  logic [AW-1:0] wb_idx_r;
  logic          wb_pend_r;
  logic [7:0]    amount_r;
  logic [6:0]    note_r;
  logic          out_valid_r;
  out_item_t     out_data_r;

  // transpose decisions
  logic signed [5:0] semi_sum;
  logic signed [5:0] semi_nxt;
  logic signed [4:0] oct_ext;
  logic signed [4:0] oct_semi_nxt;
  logic signed [4:0] oct_step_nxt;
  logic signed [4:0] oct_lo_ext;
  logic signed [4:0] oct_hi_ext;
  logic              semi_ok;
  logic              oct_ok;
  logic              len_nz;
  logic              accept_step;
  logic [7:0]        step_amount;

  always_comb begin
    semi_sum     = 6'(semis_r) + (in_data.step_up ? 6'sd1 : -6'sd1);
    oct_ext      = 5'(octave_r);
    oct_lo_ext   = 5'(oct_low_r);
    oct_hi_ext   = $signed({2'b00, oct_high_r});
    semi_nxt     = semi_sum;
    oct_semi_nxt = oct_ext;
    if (semi_sum < -SEMI_LIMIT) begin
      semi_nxt     = semi_sum + OCT_SEMIS;
      oct_semi_nxt = oct_ext - 5'sd1;
    end else if (semi_sum > SEMI_LIMIT) begin
      semi_nxt     = semi_sum - OCT_SEMIS;
      oct_semi_nxt = oct_ext + 5'sd1;
    end
    oct_step_nxt = in_data.step_up ? oct_ext + 5'sd1 : oct_ext - 5'sd1;
    semi_ok = (oct_semi_nxt >= oct_lo_ext) && (oct_semi_nxt <= oct_hi_ext);
    oct_ok  = (oct_step_nxt >= oct_lo_ext) && (oct_step_nxt <= oct_hi_ext);
    len_nz  = (seq_len_r != '0);
    accept_step = ((in_data.cmd == CMD_SEMI) && semi_ok) ||
                  ((in_data.cmd == CMD_OCTAVE) && oct_ok);
    if (in_data.cmd == CMD_SEMI) begin
      step_amount = in_data.step_up ? AMT_SEMI_UP : AMT_SEMI_DOWN;
    end else begin
      step_amount = in_data.step_up ? AMT_OCT_UP : AMT_OCT_DOWN;
    end
  end

  // playhead modulo: one restoring-remainder bit per cycle
  logic [2*LW-1:0] div_shift;
  logic [2*LW-1:0] rem_ext;
  assign div_shift = (2*LW)'(seq_len_r) << k_r;
  assign rem_ext   = (2*LW)'(rem_r);

  always_comb begin
    stat.go_mod     = (in_data.cmd == CMD_GATE) && in_data.gate_level &&
                      !gate_seen_r && len_nz;
    stat.go_shift   = accept_step && len_nz;
    stat.mod_last   = (k_r == '0);
    stat.shift_last = (LW'(walk_idx_r) == (seq_len_r - LW'(1)));
  end

  // memory ports
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic          mem_re;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wb_idx_r;
    mem_wdata = rd_data_r + amount_r;
    if (wb_pend_r) begin
      mem_we = 1'b1;
    end else if (cmd.accept && (in_data.cmd == CMD_APPEND) &&
                 (seq_len_r < LW'(MAX_STEPS))) begin
      mem_we    = 1'b1;
      mem_waddr = seq_len_r[AW-1:0];
      mem_wdata = in_data.note_value;
    end
    mem_re    = cmd.rd_play || cmd.shift_rd;
    mem_raddr = cmd.rd_play ? rem_r[AW-1:0] : walk_idx_r;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  // sequence and transpose state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_len_r   <= '0;
      playhead_r  <= '0;
      gate_seen_r <= 1'b0;
      semis_r     <= '0;
      octave_r    <= '0;
    end else begin
      if (cmd.accept) begin
        unique case (in_data.cmd)
          CMD_GATE: gate_seen_r <= in_data.gate_level;
          CMD_APPEND: begin
            if (seq_len_r < LW'(MAX_STEPS)) seq_len_r <= seq_len_r + LW'(1);
          end
          CMD_DELETE: begin
            if (len_nz) seq_len_r <= seq_len_r - LW'(1);
          end
          CMD_SEMI: begin
            if (semi_ok) begin
              semis_r  <= semi_nxt[4:0];
              octave_r <= oct_semi_nxt[3:0];
            end
          end
          CMD_OCTAVE: begin
            if (oct_ok) octave_r <= oct_step_nxt[3:0];
          end
          default: ;
        endcase
      end
      if (cmd.rd_play) begin
        playhead_r <= rem_r[AW-1:0];
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      floor_r    <= FLOOR_RST;
      ceiling_r  <= CEILING_RST;
      oct_low_r  <= OCT_LOW_RST;
      oct_high_r <= OCT_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_NOTE_FLOOR:   floor_r    <= cfg_wdata;
        CFG_NOTE_CEILING: ceiling_r  <= cfg_wdata;
        CFG_OCT_LOWEST:   oct_low_r  <= cfg_wdata[3:0];
        CFG_OCT_HIGHEST:  oct_high_r <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // walk and modulo working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_pend_r <= 1'b0;
    end else begin
      wb_pend_r <= cmd.shift_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rem_r      <= LW'(playhead_r) + LW'(1);
      k_r        <= KW'(LW - 1);
      walk_idx_r <= '0;
      amount_r   <= step_amount;
    end else begin
      if (cmd.mod_step) begin
        if (rem_ext >= div_shift) rem_r <= rem_r - div_shift[LW-1:0];
        k_r <= k_r - KW'(1);
      end
      if (cmd.shift_rd) begin
        walk_idx_r <= walk_idx_r + AW'(1);
      end
    end
    if (cmd.shift_rd) begin
      wb_idx_r <= walk_idx_r;
    end
  end

  // note clamp, then DAC scaling
  logic signed [8:0] note_num;
  logic signed [8:0] note_clamped;
  logic [12:0]       code_full;
  logic [AW+4:0]     ph_ext;

  always_comb begin
    note_num     = 9'(signed'(rd_data_r)) + NOTE_OFFSET;
    note_clamped = note_num;
    if (note_clamped < $signed({2'b00, floor_r})) note_clamped = $signed({2'b00, floor_r});
    if (note_clamped > $signed({2'b00, ceiling_r})) note_clamped = $signed({2'b00, ceiling_r});
    code_full = (13'(note_r) << 5) + (13'(note_r) << 1);
    ph_ext    = (AW+5)'(playhead_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.clamp) begin
      note_r <= note_clamped[6:0];
    end
    if (cmd.emit) begin
      out_data_r.dac_code   <= (code_full > DAC_MAX) ? DAC_MAX[11:0] : code_full[11:0];
      out_data_r.step_index <= ph_ext[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// File: rtl/cvss_ctrl.sv
// Controller state machine: command dispatch, modulo, read, emit and walk sequencing.
`default_nettype none
`include "cv_note_step_sequencer_top_assert.svh"
module cvss_ctrl import cvss_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire dp_stat_t stat,
  output ctl_cmd_t      cmd,
  output logic          busy
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MOD   = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_CLAMP = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;
  localparam logic [2:0] ST_SHIFT = 3'd5;
  localparam logic [2:0] ST_TAIL  = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          if (stat.go_mod) begin
            state_nxt = ST_MOD;
          end else if (stat.go_shift) begin
            state_nxt = ST_SHIFT;
          end
        end
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_last) state_nxt = ST_READ;
      end
      ST_READ: begin
        cmd.rd_play = 1'b1;
        state_nxt   = ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd.clamp = 1'b1;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_SHIFT: begin
        cmd.shift_rd = 1'b1;
        if (stat.shift_last) state_nxt = ST_TAIL;
      end
      // last write-back of the walk drains here
      ST_TAIL: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

  `CVSS_ASSERT_NXT(a_emit_returns_idle, clk, rst_n, state_r == ST_EMIT, state_r == ST_IDLE)
  `CVSS_ASSERT_NXT(a_shift_request, clk, rst_n, start && !busy && stat.go_shift && !stat.go_mod, state_r == ST_SHIFT)
  `CVSS_ASSERT_NXT(a_mod_to_read, clk, rst_n, state_r == ST_MOD && stat.mod_last, state_r == ST_READ)
  `CVSS_ASSERT_IMP(a_one_action, clk, rst_n, 1'b1, $onehot0(cmd))

endmodule
`default_nettype wire

// File: rtl/cv_note_step_sequencer_top.sv
// Gate request with a rising edge and a non-empty store: busy through MOD, READ, CLAMP and
// EMIT, then out_valid strobes for one cycle; MOD walks the LW = clog2(MAX_STEPS+1) bits.
// Accepted transpose step with a non-empty store: busy through SHIFT and TAIL, one note per cycle.
// Other requests, refused steps included, finish in the accepting cycle; busy stays low.
// Synchronous active-low reset clears control and sequence state and loads config defaults;
// the note memory is not cleared. The result strobe cannot be stalled.
`default_nettype none
module cv_note_step_sequencer_top import cvss_pkg::*; #(
  parameter int MAX_STEPS = MAX_STEPS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire in_item_t   in_data,
  output logic            out_valid,
  output out_item_t       out_data,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_idx,
  input  wire logic [6:0] cfg_wdata
);

  ctl_cmd_t ctl_cmd;
  dp_stat_t dp_stat;

  cvss_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (dp_stat),
    .cmd   (ctl_cmd),
    .busy  (busy)
  );

  cvss_datapath #(
    .MAX_STEPS (MAX_STEPS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cmd       (ctl_cmd),
    .stat      (dp_stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
